/* rtl/core/pld_pkg.sv */
// Package for the partition label detector.
// Constants, magic values, label codes and the structs shared by the core modules.
// No dependencies.
package pld_pkg;

   localparam int unsigned LABEL_BYTES  = 1024;
   localparam int unsigned SECTOR_BYTES = LABEL_BYTES / 2;
   localparam int unsigned COUNT_W      = $clog2(LABEL_BYTES + 1);

   localparam logic [COUNT_W-1:0] LAST_LABEL_IDX = COUNT_W'(LABEL_BYTES - 1);
   localparam logic [COUNT_W-1:0] LABEL_DONE     = COUNT_W'(LABEL_BYTES);
   localparam logic [COUNT_W-1:0] HEAD_END       = COUNT_W'(4);
   localparam logic [COUNT_W-1:0] TAIL_START     = COUNT_W'(SECTOR_BYTES - 4);
   localparam logic [COUNT_W-1:0] SECTOR_END     = COUNT_W'(SECTOR_BYTES);
   localparam logic [COUNT_W-1:0] SEC2_END       = COUNT_W'(SECTOR_BYTES + 4);

   // magic values
   localparam logic [31:0] VOLHDR_MAGIC    = 32'h0be5_a941;
   localparam logic [31:0] EBCDIC_MAGIC_BE = 32'hc9c2_d4c1;
   localparam logic [31:0] EBCDIC_MAGIC_LE = 32'hc1d4_c2c9;
   localparam logic [15:0] XORLBL_MAGIC_BE = 16'hdabe;
   localparam logic [15:0] XORLBL_MAGIC_LE = 16'hbeda;
   localparam logic [15:0] DOS_SIGNATURE   = {8'h55, 8'haa};
   localparam logic [15:0] PMAP_DRV_MAGIC  = 16'h4552;
   localparam logic [15:0] PMAP_PART_MAGIC = 16'h504d;
   localparam logic [15:0] PMAP_OLD_MAGIC  = 16'h5453;
   localparam logic [31:0] DISKLBL_MAGIC_BE = 32'h8256_4557;
   localparam logic [31:0] DISKLBL_MAGIC_LE = 32'h5745_5682;

   typedef enum logic [2:0] {
      LABEL_NONE    = 3'd0,
      LABEL_VOLHDR  = 3'd1,
      LABEL_XORLBL  = 3'd2,
      LABEL_EBCDIC  = 3'd3,
      LABEL_DOS     = 3'd4,
      LABEL_PMAP    = 3'd5,
      LABEL_DISKLBL = 3'd6
   } label_code_type;

   typedef struct packed {
      logic [31:0] head_bytes;
      logic [31:0] tail_bytes;
      logic [31:0] sec2_magic;
      logic [31:0] word_sum;
      logic [7:0]  even_xor;
      logic [7:0]  odd_xor;
   } label_info_type;

   typedef struct packed {
      logic emit;    // this transfer produces a result
      logic full;    // result is the full-label classification
   } scan_status_type;

endpackage

/* rtl/core/pld_accum.sv */
// Running scan state over the first LABEL_BYTES bytes of a stream.
// Keeps byte count, word sum, byte XORs and magic bytes; flags result transfers.
// Depends on pld_pkg.
module pld_accum import pld_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            take,
   input  logic [7:0]      data_byte,
   input  logic            last,
   output label_info_type  info,
   output scan_status_type status
);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic               given_ff, given_in;
   logic [23:0]        shift_ff, shift_in;
   logic [31:0]        sum_ff, sum_in;
   logic [7:0]         even_ff, even_in;
   logic [7:0]         odd_ff, odd_in;
   logic [31:0]        head_ff, head_in;
   logic [31:0]        tail_ff, tail_in;
   logic [31:0]        sec2_ff, sec2_in;
   logic               scanning;
   logic               in_sector;

   assign scanning  = !given_ff && (count_ff < LABEL_DONE);
   assign in_sector = count_ff < SECTOR_END;

   assign status.full = !given_ff && (count_ff == LAST_LABEL_IDX);
   assign status.emit = status.full || (last && !given_ff);

   always_comb begin
      count_in = count_ff;
      given_in = given_ff;
      shift_in = shift_ff;
      sum_in   = sum_ff;
      even_in  = even_ff;
      odd_in   = odd_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      sec2_in  = sec2_ff;
      if (take) begin
         if (last) begin
            // end of device: back to offset zero
            count_in = '0;
            given_in = 1'b0;
            shift_in = '0;
            sum_in   = '0;
            even_in  = '0;
            odd_in   = '0;
            head_in  = '0;
            tail_in  = '0;
            sec2_in  = '0;
         end else if (scanning) begin
            if (in_sector) begin
               if (count_ff[1:0] == 2'b11) begin
                  sum_in = sum_ff + {shift_ff, data_byte};
               end
               if (count_ff[0]) begin
                  odd_in = odd_ff ^ data_byte;
               end else begin
                  even_in = even_ff ^ data_byte;
               end
            end
            shift_in = {shift_ff[15:0], data_byte};
            if (count_ff < HEAD_END) begin
               head_in = {head_ff[23:0], data_byte};
            end
            if (count_ff >= TAIL_START && in_sector) begin
               tail_in = {tail_ff[23:0], data_byte};
            end
            if (!in_sector && count_ff < SEC2_END) begin
               sec2_in = {sec2_ff[23:0], data_byte};
            end
            count_in = count_ff + 1'b1;
            given_in = status.full;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         given_ff <= 1'b0;
         shift_ff <= '0;
         sum_ff   <= '0;
         even_ff  <= '0;
         odd_ff   <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         sec2_ff  <= '0;
      end else begin
         count_ff <= count_in;
         given_ff <= given_in;
         shift_ff <= shift_in;
         sum_ff   <= sum_in;
         even_ff  <= even_in;
         odd_ff   <= odd_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         sec2_ff  <= sec2_in;
      end
   end

   assign info.head_bytes = head_ff;
   assign info.tail_bytes = tail_ff;
   assign info.sec2_magic = sec2_ff;
   assign info.word_sum   = sum_ff;
   assign info.even_xor   = even_ff;
   assign info.odd_xor    = odd_ff;

`ifndef SYNTHESIS
   a_given_means_done: assert property (@(posedge clock) disable iff (reset)
      given_ff |-> count_ff == LABEL_DONE)
      else $error("result flag set before label complete");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      !given_ff |-> count_ff < LABEL_DONE)
      else $error("byte count past label without result");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (take && last) |=> (count_ff == '0 && !given_ff && sum_ff == '0))
      else $error("state not cleared after last transfer");
`endif

endmodule

/* rtl/core/pld_classify.sv */
// Priority classifier of the partition label from the collected scan state.
// Pure compare logic; first matching check wins.
// Depends on pld_pkg.
module pld_classify import pld_pkg::*; (
   input  label_info_type info,
   output label_code_type code
);

   logic [15:0] head_hi;
   logic [15:0] tail_hi;
   logic [15:0] tail_lo;
   logic        volhdr_hit;
   logic        xorlbl_hit;
   logic        ebcdic_hit;
   logic        dos_hit;
   logic        pmap_hit;
   logic        disklbl_hit;

   assign head_hi = info.head_bytes[31:16];
   assign tail_hi = info.tail_bytes[31:16];
   assign tail_lo = info.tail_bytes[15:0];

   assign volhdr_hit = (info.head_bytes == VOLHDR_MAGIC) && (info.word_sum == '0);
   assign xorlbl_hit = ((tail_hi == XORLBL_MAGIC_BE) || (tail_hi == XORLBL_MAGIC_LE))
                       && (info.even_xor == '0) && (info.odd_xor == '0);
   assign ebcdic_hit = (info.head_bytes == EBCDIC_MAGIC_BE) ||
                       (info.head_bytes == EBCDIC_MAGIC_LE);
   assign dos_hit    = tail_lo == DOS_SIGNATURE;
   assign pmap_hit   = (head_hi == PMAP_DRV_MAGIC) || (head_hi == PMAP_PART_MAGIC) ||
                       (head_hi == PMAP_OLD_MAGIC);
   assign disklbl_hit = (info.sec2_magic == DISKLBL_MAGIC_BE) ||
                        (info.sec2_magic == DISKLBL_MAGIC_LE);

   always_comb begin
      if (volhdr_hit) begin
         code = LABEL_VOLHDR;
      end else if (xorlbl_hit) begin
         code = LABEL_XORLBL;
      end else if (ebcdic_hit) begin
         code = LABEL_EBCDIC;
      end else if (dos_hit) begin
         code = LABEL_DOS;
      end else if (pmap_hit) begin
         code = LABEL_PMAP;
      end else if (disklbl_hit) begin
         code = LABEL_DISKLBL;
      end else begin
         code = LABEL_NONE;
      end
   end

endmodule

/* rtl/core/partition_label_detector.sv */
// Partition label detector, top level.
// Byte stream in on req_, one label code out on rsp_ per device stream.
// Depends on pld_pkg, pld_accum and pld_classify.
//
// Usage:
//   req_ channel: one disk byte per transfer from offset zero, req_last on the
//   final byte of the device. rsp_ channel: one label code per device, given
//   on the transfer of byte 1023, or code none when req_last comes earlier.
//   Bytes after 1023 are consumed without a result until req_last, after
//   which the next byte starts a new device at offset zero.
// Latency: the result is valid in the cycle after the producing transfer.
// Throughput: one byte per clock while req_ready is high; scan state updates
//   per byte, classification is compare logic on stored magic bytes and sums.
// Stall: the result register holds its code while rsp_ready is low; req_ready
//   stays high while that register is empty or being emptied, so input flows
//   on when the receiver takes the result in the same cycle.
// Reset: synchronous, clears the scan state and drops rsp_valid; the block
//   takes bytes from the first cycle after reset.
module partition_label_detector import pld_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_label_type
);

   label_info_type  info;
   scan_status_type status;
   label_code_type  class_code;
   logic            take;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [2:0]      label_ff, label_in;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   pld_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .data_byte (req_data_byte),
      .last      (req_last),
      .info      (info),
      .status    (status)
   );

   pld_classify u_classify (
      .info (info),
      .code (class_code)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      label_in     = label_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (take && status.emit) begin
         rsp_valid_in = 1'b1;
         label_in     = status.full ? class_code : LABEL_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      label_ff <= label_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_label_type = label_ff;

endmodule
